// ===== hdl/bnt_pkg.sv =====
// ----------------------------------------------------------------------------
// bnt_pkg
// Shared types and constants for the bracket nesting tracker: fence kinds,
// scan status codes, character codes and the stack control word.
// ----------------------------------------------------------------------------
`default_nettype none

package bnt_pkg;

   // Default number of fence cells in the stack chain
   localparam int STACK_DEPTH_DEFAULT = 64;

   // Width of the depth field of a result
   localparam int DEPTH_W = 7;

   // Characters that matter to the scanner
   localparam logic [7:0] CH_LPAREN   = 8'h28;  // (
   localparam logic [7:0] CH_RPAREN   = 8'h29;  // )
   localparam logic [7:0] CH_LBRACKET = 8'h5B;  // [
   localparam logic [7:0] CH_RBRACKET = 8'h5D;  // ]
   localparam logic [7:0] CH_LBRACE   = 8'h7B;  // {
   localparam logic [7:0] CH_RBRACE   = 8'h7D;  // }
   localparam logic [7:0] CH_QUOTE    = 8'h22;  // "
   localparam logic [7:0] CH_HASH     = 8'h23;  // #
   localparam logic [7:0] CH_BSLASH   = 8'h5C;  // backslash

   // Kind of an open fence, as held in one stack cell
   typedef enum logic [1:0] {
      FENCE_PAREN   = 2'd0,
      FENCE_BRACKET = 2'd1,
      FENCE_BRACE   = 2'd2
   } fence_type;

   // Scan status reported with every result
   typedef enum logic [1:0] {
      STATUS_SCAN     = 2'd0,
      STATUS_STRAY    = 2'd1,
      STATUS_MISMATCH = 2'd2,
      STATUS_OVERFLOW = 2'd3
   } status_type;

   // Control word broadcast to every cell of the stack chain
   typedef struct packed {
      logic      push;
      logic      pop;
      fence_type kind;
   } stack_op_type;

endpackage

`default_nettype wire

// ===== hdl/bnt_cell.sv =====
// ----------------------------------------------------------------------------
// bnt_cell
// One entry of the fence stack. On a push it takes the kind held by the cell
// above it, on a pop the kind held by the cell below it, otherwise it holds.
// ----------------------------------------------------------------------------
`default_nettype none

module bnt_cell (
   input  wire                        clock,
   input  wire bnt_pkg::stack_op_type op,
   input  wire bnt_pkg::fence_type    from_above,
   input  wire bnt_pkg::fence_type    from_below,
   output bnt_pkg::fence_type         kind
);

   bnt_pkg::fence_type kind_ff;
   bnt_pkg::fence_type kind_in;

   // Select shift direction
   always_comb begin
      if (op.push) begin
         kind_in = from_above;
      end else if (op.pop) begin
         kind_in = from_below;
      end else begin
         kind_in = kind_ff;
      end
   end

   // Hold the fence kind
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
   end

   assign kind = kind_ff;

endmodule

`default_nettype wire

// ===== hdl/bracket_nesting_tracker_core.sv =====
// ----------------------------------------------------------------------------
// bracket_nesting_tracker_core
// Tracks nesting of ( [ { in a character stream, with quoting and the #\"
// character literal, and reports depth, quote flag and scan status.
// ----------------------------------------------------------------------------
// The core takes one character per clock while req_tready is high and returns
// one registered result per character; a two-entry output stage lets it keep
// taking characters while a result waits on the result channel. The open
// fences sit in a row of STACK_DEPTH cells, top of stack in cell 0, and the
// whole row shifts by one place on a push or a pop, so the stack keeps pace
// with the characters whatever its depth. Set req_tuser on the first character
// of each expression to clear the scan state. After a stray closer, a mismatch
// or an overflow the status sticks and later characters are ignored until the
// next first character. Stack cells need no clearing after reset.
`default_nettype none

module bracket_nesting_tracker_core #(
   parameter int STACK_DEPTH = bnt_pkg::STACK_DEPTH_DEFAULT
) (
   input  wire        clock,
   input  wire        reset,
   // request channel
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire  [7:0] req_tdata,   // [7:0] ch
   input  wire  [0:0] req_tuser,   // [0] first
   // result channel
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [7:0] rsp_tdata,   // [6:0] depth, [7] quoted
   output logic [1:0] rsp_tuser    // [1:0] status
);

   localparam int LEVEL_W = $clog2(STACK_DEPTH + 1);
   localparam int DW      = bnt_pkg::DEPTH_W;

   typedef enum logic [1:0] {
      PREFIX_NONE        = 2'd0,
      PREFIX_HASH        = 2'd1,
      PREFIX_HASH_BSLASH = 2'd2
   } prefix_type;

   // Scan state
   logic [LEVEL_W-1:0]   level_ff, level_in;
   logic                 quote_ff, quote_in;
   bnt_pkg::status_type  status_ff, status_in;
   prefix_type           prefix_ff, prefix_in;

   // Output stage: main register and skid register
   logic                 out_v_ff, out_v_in;
   logic [DW-1:0]        out_depth_ff, out_depth_in;
   logic                 out_quote_ff, out_quote_in;
   bnt_pkg::status_type  out_status_ff, out_status_in;
   logic                 skid_v_ff, skid_v_in;
   logic [DW-1:0]        skid_depth_ff, skid_depth_in;
   logic                 skid_quote_ff, skid_quote_in;
   bnt_pkg::status_type  skid_status_ff, skid_status_in;

   logic                 req_fire;
   logic                 rsp_fire;
   logic                 first;
   logic [7:0]           ch;

   logic [LEVEL_W-1:0]   level_cur;
   logic                 quote_cur;
   bnt_pkg::status_type  status_cur;
   prefix_type           prefix_cur;

   logic                 is_open;
   logic                 is_close;
   bnt_pkg::fence_type   ch_kind;
   bnt_pkg::fence_type   top_kind;
   bnt_pkg::stack_op_type op;
   bnt_pkg::fence_type   cell_kind [STACK_DEPTH];

   logic [LEVEL_W+DW-1:0] level_ext;
   logic [DW-1:0]         new_depth;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign first    = req_tuser[0];
   assign ch       = req_tdata;

   // Stack chain: cell 0 holds the top of stack
   for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
      bnt_pkg::fence_type above;
      bnt_pkg::fence_type below;
      if (g == 0) begin : g_top
         assign above = op.kind;
      end else begin : g_mid
         assign above = cell_kind[g-1];
      end
      if (g == STACK_DEPTH - 1) begin : g_bottom
         assign below = bnt_pkg::FENCE_PAREN;
      end else begin : g_inner
         assign below = cell_kind[g+1];
      end
      bnt_cell u_cell (
         .clock      (clock),
         .op         (op),
         .from_above (above),
         .from_below (below),
         .kind       (cell_kind[g])
      );
   end

   assign top_kind = cell_kind[0];

   // Classify the character
   always_comb begin
      is_open  = 1'b0;
      is_close = 1'b0;
      ch_kind  = bnt_pkg::FENCE_PAREN;
      unique case (ch)
         bnt_pkg::CH_LPAREN: begin
            is_open = 1'b1;
            ch_kind = bnt_pkg::FENCE_PAREN;
         end
         bnt_pkg::CH_LBRACKET: begin
            is_open = 1'b1;
            ch_kind = bnt_pkg::FENCE_BRACKET;
         end
         bnt_pkg::CH_LBRACE: begin
            is_open = 1'b1;
            ch_kind = bnt_pkg::FENCE_BRACE;
         end
         bnt_pkg::CH_RPAREN: begin
            is_close = 1'b1;
            ch_kind  = bnt_pkg::FENCE_PAREN;
         end
         bnt_pkg::CH_RBRACKET: begin
            is_close = 1'b1;
            ch_kind  = bnt_pkg::FENCE_BRACKET;
         end
         bnt_pkg::CH_RBRACE: begin
            is_close = 1'b1;
            ch_kind  = bnt_pkg::FENCE_BRACE;
         end
         default: begin
            is_open  = 1'b0;
            is_close = 1'b0;
         end
      endcase
   end

   // Clear state ahead of the first character of an expression
   always_comb begin
      if (first) begin
         level_cur  = '0;
         quote_cur  = 1'b0;
         status_cur = bnt_pkg::STATUS_SCAN;
         prefix_cur = PREFIX_NONE;
      end else begin
         level_cur  = level_ff;
         quote_cur  = quote_ff;
         status_cur = status_ff;
         prefix_cur = prefix_ff;
      end
   end

   // Scan one character
   always_comb begin
      level_in  = level_ff;
      quote_in  = quote_ff;
      status_in = status_ff;
      prefix_in = prefix_ff;
      op.push   = 1'b0;
      op.pop    = 1'b0;
      op.kind   = ch_kind;
      if (req_fire) begin
         level_in  = level_cur;
         quote_in  = quote_cur;
         status_in = status_cur;
         prefix_in = prefix_cur;
         if (status_cur == bnt_pkg::STATUS_SCAN) begin
            // track the character literal prefix
            priority if (ch == bnt_pkg::CH_HASH) begin
               prefix_in = PREFIX_HASH;
            end else if (ch == bnt_pkg::CH_BSLASH && prefix_cur == PREFIX_HASH) begin
               prefix_in = PREFIX_HASH_BSLASH;
            end else begin
               prefix_in = PREFIX_NONE;
            end

            priority if (ch == bnt_pkg::CH_QUOTE) begin
               if (prefix_cur != PREFIX_HASH_BSLASH) begin
                  quote_in = !quote_cur;
               end
            end else if (quote_cur) begin
               // fences do not count inside quotes
            end else if (is_open) begin
               if (level_cur == LEVEL_W'(STACK_DEPTH)) begin
                  status_in = bnt_pkg::STATUS_OVERFLOW;
               end else begin
                  op.push  = 1'b1;
                  level_in = level_cur + LEVEL_W'(1);
               end
            end else if (is_close) begin
               priority if (level_cur == '0) begin
                  status_in = bnt_pkg::STATUS_STRAY;
               end else if (top_kind == ch_kind) begin
                  op.pop   = 1'b1;
                  level_in = level_cur - LEVEL_W'(1);
               end else begin
                  status_in = bnt_pkg::STATUS_MISMATCH;
               end
            end else begin
               // neutral byte
            end
         end
      end
   end

   assign level_ext = {{DW{1'b0}}, level_in};
   assign new_depth = level_ext[DW-1:0];

   // Output stage with skid register
   assign req_tready = !skid_v_ff;

   always_comb begin
      out_v_in       = out_v_ff;
      out_depth_in   = out_depth_ff;
      out_quote_in   = out_quote_ff;
      out_status_in  = out_status_ff;
      skid_v_in      = skid_v_ff;
      skid_depth_in  = skid_depth_ff;
      skid_quote_in  = skid_quote_ff;
      skid_status_in = skid_status_ff;
      if (req_fire) begin
         if (!out_v_ff || rsp_fire) begin
            out_v_in      = 1'b1;
            out_depth_in  = new_depth;
            out_quote_in  = quote_in;
            out_status_in = status_in;
         end else begin
            skid_v_in      = 1'b1;
            skid_depth_in  = new_depth;
            skid_quote_in  = quote_in;
            skid_status_in = status_in;
         end
      end else if (rsp_fire) begin
         if (skid_v_ff) begin
            out_depth_in  = skid_depth_ff;
            out_quote_in  = skid_quote_ff;
            out_status_in = skid_status_ff;
            skid_v_in     = 1'b0;
         end else begin
            out_v_in = 1'b0;
         end
      end
   end

   // Hold state and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff  <= '0;
         quote_ff  <= 1'b0;
         status_ff <= bnt_pkg::STATUS_SCAN;
         prefix_ff <= PREFIX_NONE;
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         level_ff  <= level_in;
         quote_ff  <= quote_in;
         status_ff <= status_in;
         prefix_ff <= prefix_in;
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
      out_depth_ff   <= out_depth_in;
      out_quote_ff   <= out_quote_in;
      out_status_ff  <= out_status_in;
      skid_depth_ff  <= skid_depth_in;
      skid_quote_ff  <= skid_quote_in;
      skid_status_ff <= skid_status_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {out_quote_ff, out_depth_ff};
   assign rsp_tuser  = out_status_ff;

   // Never shift the chain both ways at once
   a_push_pop_excl: assert property (@(posedge clock) disable iff (reset)
      !(op.push && op.pop))
      else $error("stack push and pop in the same cycle");

   // Keep the level within the cell count
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LEVEL_W'(STACK_DEPTH))
      else $error("stack level beyond stack depth");

   // Fill the skid register only behind a full main register
   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid register valid with main register empty");

   // Freeze the level once the scan has stopped
   a_stopped_hold: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !first && status_ff != bnt_pkg::STATUS_SCAN)
      |=> level_ff == $past(level_ff))
      else $error("level changed after scan stopped");

   // Move the level only by a push or a pop without a new expression
   a_level_step: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !first && !op.push && !op.pop) |=> level_ff == $past(level_ff))
      else $error("level changed without a stack operation");

endmodule

`default_nettype wire

// ===== test/tb_bracket_nesting_tracker_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bracket_nesting_tracker_core
// Self-checking bench for the bracket nesting tracker core. A scoreboard
// tracks fences, quoting, the #\" literal and the sticky stop status for every
// accepted character, then checks each result transaction field by field.
// Stimulus is a directed opening, then random expressions with nesting,
// quoted strings, literals, stray and wrong closers, overflow runs and noise.
// ----------------------------------------------------------------------------

module tb_bracket_nesting_tracker_core;

   localparam int          FENCE_CELLS   = bnt_pkg::STACK_DEPTH_DEFAULT;
   localparam int          DEPTH_W       = bnt_pkg::DEPTH_W;
   localparam int          TARGET_ITEMS  = 1550;
   localparam int          STALL_LIMIT   = 2000;
   localparam int          SETTLE_CYCLES = 10;

   // Literal prefix tracking codes
   localparam logic [1:0]  PFX_NONE    = 2'd0;
   localparam logic [1:0]  PFX_HASH    = 2'd1;
   localparam logic [1:0]  PFX_LITERAL = 2'd2;

   typedef struct packed {
      logic [DEPTH_W-1:0]  depth;
      logic                quoted;
      bnt_pkg::status_type status;
   } nest_result_type;

   // -------------------------------------------------------------------------
   // Scoreboard: nesting predictor plus the queue of expected results
   // -------------------------------------------------------------------------
   class nesting_scoreboard;
      bnt_pkg::fence_type  fences[FENCE_CELLS];
      int unsigned         level;
      logic                quote;
      bnt_pkg::status_type status;
      logic [1:0]          prefix;
      nest_result_type     expected_results[$];
      int unsigned         errors;
      int unsigned         checked;
      int unsigned         deepest;
      int unsigned         stray_stops;
      int unsigned         mismatch_stops;
      int unsigned         overflow_stops;

      function new();
         level          = 0;
         quote          = 1'b0;
         status         = bnt_pkg::STATUS_SCAN;
         prefix         = PFX_NONE;
         errors         = 0;
         checked        = 0;
         deepest        = 0;
         stray_stops    = 0;
         mismatch_stops = 0;
         overflow_stops = 0;
      endfunction

      function bit is_opener(logic [7:0] c);
         return c == bnt_pkg::CH_LPAREN || c == bnt_pkg::CH_LBRACKET ||
                c == bnt_pkg::CH_LBRACE;
      endfunction

      function bit is_closer(logic [7:0] c);
         return c == bnt_pkg::CH_RPAREN || c == bnt_pkg::CH_RBRACKET ||
                c == bnt_pkg::CH_RBRACE;
      endfunction

      function bnt_pkg::fence_type kind_of(logic [7:0] c);
         if (c == bnt_pkg::CH_LPAREN || c == bnt_pkg::CH_RPAREN)
            return bnt_pkg::FENCE_PAREN;
         if (c == bnt_pkg::CH_LBRACKET || c == bnt_pkg::CH_RBRACKET)
            return bnt_pkg::FENCE_BRACKET;
         return bnt_pkg::FENCE_BRACE;
      endfunction

      function int unsigned pending();
         return expected_results.size();
      endfunction

      // Advance the prediction by one accepted character
      function void note_char(logic [7:0] c, logic first);
         nest_result_type r;
         logic [1:0]      seen;
         if (first) begin
            level  = 0;
            quote  = 1'b0;
            status = bnt_pkg::STATUS_SCAN;
            prefix = PFX_NONE;
         end
         if (status == bnt_pkg::STATUS_SCAN) begin
            seen = prefix;
            if (c == bnt_pkg::CH_HASH) prefix = PFX_HASH;
            else if (c == bnt_pkg::CH_BSLASH && seen == PFX_HASH) prefix = PFX_LITERAL;
            else prefix = PFX_NONE;

            if (c == bnt_pkg::CH_QUOTE) begin
               // the quote of a #\" literal does not toggle quoting
               if (seen != PFX_LITERAL) quote = !quote;
            end else if (!quote) begin
               if (is_opener(c)) begin
                  if (level >= FENCE_CELLS) begin
                     status = bnt_pkg::STATUS_OVERFLOW;
                     overflow_stops++;
                  end else begin
                     fences[level] = kind_of(c);
                     level++;
                  end
               end else if (is_closer(c)) begin
                  if (level == 0) begin
                     status = bnt_pkg::STATUS_STRAY;
                     stray_stops++;
                  end else if (fences[level-1] == kind_of(c)) begin
                     level--;
                  end else begin
                     status = bnt_pkg::STATUS_MISMATCH;
                     mismatch_stops++;
                  end
               end
            end
         end
         if (level > deepest) deepest = level;
         r.depth  = DEPTH_W'(level);
         r.quoted = quote;
         r.status = status;
         expected_results.push_back(r);
      endfunction

      // Compare one accepted result with the oldest expectation
      function void check_result(logic [DEPTH_W-1:0] depth, logic quoted,
                                 logic [1:0] stat);
         nest_result_type e;
         if (expected_results.size() == 0) begin
            $error("unexpected result: depth %0d quoted %0d status %0d",
                   depth, quoted, stat);
            errors++;
            return;
         end
         e = expected_results.pop_front();
         checked++;
         if (depth !== e.depth) begin
            $error("depth: expected %0d, got %0d", e.depth, depth);
            errors++;
         end
         if (quoted !== e.quoted) begin
            $error("quoted: expected %0d, got %0d", e.quoted, quoted);
            errors++;
         end
         if (stat !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, stat);
            errors++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and DUT
   // -------------------------------------------------------------------------
   logic       clock;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // [7:0] ch
   logic [0:0] req_tuser  = 1'b0;    // [0] first
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [6:0] depth, [7] quoted
   logic [1:0] rsp_tuser;            // [1:0] status

   nesting_scoreboard sb = new();

   bit          calm        = 1'b0;
   bit          expr_start  = 1'b0;
   bit          trailing    = 1'b0;
   int unsigned stim_count  = 0;
   int unsigned chars_in    = 0;
   int unsigned stall_count = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   bracket_nesting_tracker_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Stall the result channel at random, except in calm stretches
   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 12);
   end

   // Monitor both channels and watch for a hung handshake
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.note_char(req_tdata, req_tuser[0]);
            chars_in++;
         end
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata[DEPTH_W-1:0], rsp_tdata[7], rsp_tuser);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            stall_count = 0;
         else
            stall_count++;
         if (stall_count >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   function automatic logic [7:0] opener_char(bnt_pkg::fence_type k);
      case (k)
         bnt_pkg::FENCE_PAREN:   return bnt_pkg::CH_LPAREN;
         bnt_pkg::FENCE_BRACKET: return bnt_pkg::CH_LBRACKET;
         default:                return bnt_pkg::CH_LBRACE;
      endcase
   endfunction

   function automatic logic [7:0] closer_char(bnt_pkg::fence_type k);
      case (k)
         bnt_pkg::FENCE_PAREN:   return bnt_pkg::CH_RPAREN;
         bnt_pkg::FENCE_BRACKET: return bnt_pkg::CH_RBRACKET;
         default:                return bnt_pkg::CH_RBRACE;
      endcase
   endfunction

   function automatic bnt_pkg::fence_type random_kind();
      return bnt_pkg::fence_type'($urandom_range(2));
   endfunction

   // Random byte that the scanner treats as neutral
   function automatic logic [7:0] plain_byte();
      logic [7:0] c;
      do c = 8'($urandom_range(255));
      while (c == bnt_pkg::CH_LPAREN || c == bnt_pkg::CH_RPAREN ||
             c == bnt_pkg::CH_LBRACKET || c == bnt_pkg::CH_RBRACKET ||
             c == bnt_pkg::CH_LBRACE || c == bnt_pkg::CH_RBRACE ||
             c == bnt_pkg::CH_QUOTE || c == bnt_pkg::CH_HASH ||
             c == bnt_pkg::CH_BSLASH);
      return c;
   endfunction

   // Drive one character and hold it until the transaction completes
   task automatic send_char(input logic [7:0] c, input logic first);
      while (!calm && $urandom_range(99) < 12) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tuser  <= first;
      do @(posedge clock); while (!req_tready);
      if (!trailing) stim_count++;
   endtask

   // Send a character of the current expression, flagging its first one
   task automatic emit(input logic [7:0] c);
      logic f;
      f = expr_start;
      expr_start = 1'b0;
      send_char(c, f);
   endtask

   task automatic emit_literal();
      emit(bnt_pkg::CH_HASH);
      emit(bnt_pkg::CH_BSLASH);
      emit(bnt_pkg::CH_QUOTE);
   endtask

   // Characters after a stop, which the block ignores
   task automatic emit_trailing();
      trailing = 1'b1;
      repeat ($urandom_range(3)) begin
         if ($urandom_range(1)) emit(opener_char(random_kind()));
         else emit(8'($urandom_range(255)));
      end
      trailing = 1'b0;
   endtask

   // Hold off the sender until every expected result has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // One expression: deep_target > 0 gives a straight run of openers
   task automatic send_expression(input int unsigned deep_target);
      bnt_pkg::fence_type open_kinds[$];
      bnt_pkg::fence_type k;
      int unsigned        pick;
      bit                 quote_open;
      quote_open = 1'b0;
      expr_start = 1'b1;
      if (deep_target > 0) begin
         repeat (deep_target) begin
            k = random_kind();
            open_kinds.push_back(k);
            emit(opener_char(k));
         end
         if (deep_target > FENCE_CELLS) begin
            emit_trailing();
            return;
         end
         while (open_kinds.size() > 0) emit(closer_char(open_kinds.pop_back()));
         return;
      end

      repeat ($urandom_range(40, 4)) begin
         pick = $urandom_range(99);
         if (quote_open) begin
            if (pick < 15) begin
               emit(bnt_pkg::CH_QUOTE);
               quote_open = 1'b0;
            end else if (pick < 25) begin
               emit_literal();
            end else if (pick < 55) begin
               k = random_kind();
               emit($urandom_range(1) ? opener_char(k) : closer_char(k));
            end else begin
               emit(plain_byte());
            end
         end else if (pick < 35 && open_kinds.size() < 12) begin
            k = random_kind();
            open_kinds.push_back(k);
            emit(opener_char(k));
         end else if (pick < 65 && open_kinds.size() > 0) begin
            emit(closer_char(open_kinds.pop_back()));
         end else if (pick < 72) begin
            emit(bnt_pkg::CH_QUOTE);
            quote_open = 1'b1;
         end else if (pick < 78) begin
            emit_literal();
         end else if (pick < 82) begin
            emit($urandom_range(1) ? bnt_pkg::CH_HASH : bnt_pkg::CH_BSLASH);
         end else begin
            emit(plain_byte());
         end
      end

      // close out the expression, sometimes ending on an error
      if (quote_open && $urandom_range(1)) begin
         emit(bnt_pkg::CH_QUOTE);
         quote_open = 1'b0;
      end
      if (!quote_open) begin
         pick = $urandom_range(99);
         if (pick < 15 && open_kinds.size() > 0) begin
            k = open_kinds.pop_back();
            emit(closer_char(bnt_pkg::fence_type'((k + 1) % 3)));
            emit_trailing();
         end else begin
            while (open_kinds.size() > 0) emit(closer_char(open_kinds.pop_back()));
            if (pick < 40) begin
               emit(closer_char(random_kind()));
               emit_trailing();
            end
         end
      end
   endtask

   // Random bytes with a random first flag
   task automatic send_noise();
      repeat ($urandom_range(8, 1))
         send_char(8'($urandom_range(255)), ($urandom_range(9) == 0));
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // nest and unwind each kind, then neutral extremes
      send_char(bnt_pkg::CH_LPAREN,   1'b1);
      send_char(bnt_pkg::CH_LBRACKET, 1'b0);
      send_char(bnt_pkg::CH_LBRACE,   1'b0);
      send_char(bnt_pkg::CH_RBRACE,   1'b0);
      send_char(bnt_pkg::CH_RBRACKET, 1'b0);
      send_char(bnt_pkg::CH_RPAREN,   1'b0);
      send_char(8'h00,                1'b0);
      send_char(8'hFF,                1'b0);
      // character literal outside quotes leaves quoting off
      send_char(bnt_pkg::CH_HASH,     1'b0);
      send_char(bnt_pkg::CH_BSLASH,   1'b0);
      send_char(bnt_pkg::CH_QUOTE,    1'b0);
      // quoted string: fences ignored, literal quote skipped
      send_char(bnt_pkg::CH_QUOTE,    1'b0);
      send_char(bnt_pkg::CH_LPAREN,   1'b0);
      send_char(bnt_pkg::CH_HASH,     1'b0);
      send_char(bnt_pkg::CH_BSLASH,   1'b0);
      send_char(bnt_pkg::CH_QUOTE,    1'b0);
      send_char(bnt_pkg::CH_QUOTE,    1'b0);
      // stray closer stops, later characters ignored
      send_char(bnt_pkg::CH_RPAREN,   1'b0);
      send_char(bnt_pkg::CH_LPAREN,   1'b0);
      // wrong closer
      send_char(bnt_pkg::CH_LPAREN,   1'b1);
      send_char(bnt_pkg::CH_RBRACKET, 1'b0);
      send_char(bnt_pkg::CH_LBRACE,   1'b0);
      // backslash without hash, then a quote toggles
      send_char(bnt_pkg::CH_BSLASH,   1'b1);
      send_char(bnt_pkg::CH_QUOTE,    1'b0);
      // stray closer as the very first character
      send_char(bnt_pkg::CH_RBRACE,   1'b1);

      drain_results();

      // overflow first, then a mix of random expressions and noise
      send_expression(FENCE_CELLS + 1);
      while (stim_count < TARGET_ITEMS) begin
         calm <= (stim_count > 500 && stim_count < 800);
         if (stim_count > 1000 && stim_count < 1050) drain_results();
         if ($urandom_range(99) < 15) send_noise();
         else if ($urandom_range(99) < 8)
            send_expression($urandom_range(FENCE_CELLS + 2, FENCE_CELLS - 2));
         else send_expression(0);
      end

      // wait for the last results, then let the pipeline settle
      calm <= 1'b0;
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Checked %0d results from %0d characters, deepest nesting %0d.",
               sb.checked, chars_in, sb.deepest);
      $display("Stops seen: %0d stray closer, %0d mismatch, %0d overflow.",
               sb.stray_stops, sb.mismatch_stops, sb.overflow_stops);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
